>>> hdl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared codes for the first-fit segment allocator: request codes, result
// status codes, listing limits and the sequencer state type.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   localparam int STATUS_W = 3;
   localparam int REQ_W    = 3;
   localparam int FIDX_W   = 4;
   localparam int LIST_MAX = 16;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ALLOC     = 3'd0;
   localparam logic [REQ_W-1:0] REQ_RELEASE   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_TRANSLATE = 3'd2;
   localparam logic [REQ_W-1:0] REQ_LIST_USED = 3'd3;
   localparam logic [REQ_W-1:0] REQ_LIST_FREE = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXISTS   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOMEM    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADOFF   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BADSIZE  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd6;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd7;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_DECIDE,
      S_CMP_RD,
      S_CMP_EV,
      S_CMP_TAIL,
      S_PLACE,
      S_INS_RD,
      S_INS_WR,
      S_INS_FIN1,
      S_INS_FIN2,
      S_REL_RD,
      S_REL_EV,
      S_REL_MERGE,
      S_RM_RD,
      S_RM_WR,
      S_LCNT_RD,
      S_LCNT_EV,
      S_LEMT_RD,
      S_LEMT_EV
   } state_type;

endpackage

>>> hdl/ffsa_ram.sv
// ----------------------------------------------------------------------------
// ffsa_ram
// Segment table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 50,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// Address-ordered segment table with first-fit allocate, coalescing release,
// compaction, offset translation and used/free listings.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests: drive req_type, req_process_id, req_amount and pulse start;
//    the beat is taken on a clock edge with start high and busy low. busy
//    stays high until the last result of the request has been shown.
//  - Results: each result beat is on the rsp_ ports for one cycle, marked by
//    rsp_valid; rsp_last flags the final beat. The receiver cannot stall.
//  - Allocate, release and translate give one beat; listings give up to 16
//    beats. Unknown request codes give no beat.
//  - Table: the table sits in one memory with one read port and registered
//    read data; every table walk handles one entry at a time (read, then
//    evaluate). Translate is one scan; allocate is a scan plus, when needed,
//    a compaction walk and an insert shift; release is a scan, a merge and,
//    when needed, a removal shift; listings are a count pass, then an emit pass.
//  - CSR: ram_size at byte address 0, written over the APB-style port only
//    while the block is idle. A write clamps to 1..2^ADDR_BITS and rebuilds
//    the table as one free segment (busy high meanwhile).
//  - Reset: ram_size returns to 2^ADDR_BITS and the table is rebuilt in the
//    first cycle after reset; no clearing sweep is needed since entries
//    beyond the live count are never read.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator
   import ffsa_pkg::*;
#(
   parameter int SEGMENTS  = 16,
   parameter int ADDR_BITS = 20,
   parameter int ID_BITS   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  logic [REQ_W-1:0]       req_type,
   input  logic [ID_BITS-1:0]     req_process_id,
   input  logic [ADDR_BITS:0]     req_amount,
   // result channel
   output logic                   rsp_valid,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [ID_BITS-1:0]     rsp_owner_id,
   output logic [ADDR_BITS-1:0]   rsp_seg_base,
   output logic [ADDR_BITS-1:0]   rsp_seg_bound,
   output logic [ADDR_BITS-1:0]   rsp_phys_addr,
   output logic [FIDX_W-1:0]      rsp_free_index,
   output logic                   rsp_compacted,
   output logic                   rsp_last,
   // csr port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int SW = ADDR_BITS + 1;           // size width
   localparam int CW = $clog2(SEGMENTS + 1);    // count width
   localparam int IW = $clog2(SEGMENTS);        // table index width

   typedef struct packed {
      logic               used;
      logic [ID_BITS-1:0] owner;
      logic [SW-1:0]      size;
      logic [ADDR_BITS-1:0] base;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [ID_BITS-1:0]   owner;
      logic [ADDR_BITS-1:0] base;
      logic [ADDR_BITS-1:0] bound;
      logic [ADDR_BITS-1:0] phys;
      logic [FIDX_W-1:0]    fidx;
      logic                 comp;
      logic                 last;
   } rsp_type;

   localparam int EW = $bits(entry_type);

   function automatic rsp_type mk_rsp(input logic [STATUS_W-1:0] st,
                                      input logic [ID_BITS-1:0] own,
                                      input logic [ADDR_BITS-1:0] b,
                                      input logic [ADDR_BITS-1:0] bd,
                                      input logic [ADDR_BITS-1:0] ph,
                                      input logic [FIDX_W-1:0] fi,
                                      input logic cp,
                                      input logic ls);
      rsp_type r;
      r.status = st;
      r.owner  = own;
      r.base   = b;
      r.bound  = bd;
      r.phys   = ph;
      r.fidx   = fi;
      r.comp   = cp;
      r.last   = ls;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [SW-1:0]        ram_size_ff, ram_size_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [SW-1:0]        free_total_ff, free_total_in;
   logic [REQ_W-1:0]     req_ff, req_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [SW-1:0]        amt_ff, amt_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 hit_ff, hit_in;
   logic [CW-1:0]        hit_idx_ff, hit_idx_in;
   logic [ADDR_BITS-1:0] hit_base_ff, hit_base_in;
   logic [SW-1:0]        hit_size_ff, hit_size_in;
   logic                 prev_used_ff, prev_used_in;
   logic [ADDR_BITS-1:0] prev_base_ff, prev_base_in;
   logic [SW-1:0]        prev_size_ff, prev_size_in;
   logic                 fit_ff, fit_in;
   logic [CW-1:0]        fit_idx_ff, fit_idx_in;
   logic [ADDR_BITS-1:0] fit_base_ff, fit_base_in;
   logic [SW-1:0]        fit_size_ff, fit_size_in;
   logic                 nxf_ff, nxf_in;
   logic [SW-1:0]        nx_size_ff, nx_size_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [4:0]           k_ff, k_in;
   logic                 comp_ff, comp_in;
   logic [CW-1:0]        nw_ff, nw_in;
   logic [SW-1:0]        next_base_ff, next_base_in;
   logic [1:0]           rm_k_ff, rm_k_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // memory port
   logic                 mem_we;
   logic [IW-1:0]        mem_waddr;
   entry_type            mem_wdata;
   logic [IW-1:0]        mem_raddr;
   logic [EW-1:0]        mem_rdata;
   entry_type            e;

   ffsa_ram #(
      .DEPTH (SEGMENTS),
      .WIDTH (EW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign e = entry_type'(mem_rdata);

   // ------------------------------------------------------------------------
   // shared conditions
   // ------------------------------------------------------------------------
   logic          cfg_wr;
   logic          accept;
   logic          in_range;
   logic          is_match;
   logic          is_fit;
   logic          want_used;
   logic          lst_match;
   logic          k_last;
   logic          tail_ok;
   logic          table_full;
   logic          rel_has_next;
   logic          pf;
   logic [1:0]    rm_k_calc;
   logic [SW-1:0] merged_size;
   logic          rm_more;
   logic [CW:0]   rm_src;
   logic [63:0]   wv;

   assign cfg_wr    = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign accept    = start && (state_ff == S_IDLE);
   assign in_range  = idx_ff < count_ff;
   assign is_match  = e.used && (e.owner == id_ff);
   assign is_fit    = !e.used && (e.size >= amt_ff);
   assign want_used = (req_ff == REQ_LIST_USED);
   assign lst_match = (e.used == want_used);
   assign k_last    = (32'(k_ff) + 1) == 32'(cnt_ff);
   assign tail_ok   = (free_total_ff != '0) && (32'(nw_ff) < SEGMENTS);
   assign table_full = 32'(count_ff) >= SEGMENTS;
   assign rel_has_next = ((CW + 1)'(hit_idx_ff) + (CW + 1)'(1)) < (CW + 1)'(count_ff);

   // release merge: left neighbor free, right neighbor free (nxf)
   assign pf = (hit_idx_ff != '0) && !prev_used_ff;
   assign merged_size = hit_size_ff + (nxf_ff ? nx_size_ff : '0) + (pf ? prev_size_ff : '0);
   assign rm_k_calc = pf ? (2'd1 + {1'b0, nxf_ff}) : {1'b0, nxf_ff};
   assign rm_src  = (CW + 1)'(idx_ff) + (CW + 1)'(rm_k_ff);
   assign rm_more = rm_src < (CW + 1)'(count_ff);

   assign wv = 64'(csr_pwdata);

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: state_in = S_IDLE;
         S_IDLE: begin
            if (cfg_wr) begin
               state_in = S_INIT;
            end else if (start) begin
               unique case (req_type)
                  REQ_ALLOC:                 state_in = (req_amount == '0) ? S_IDLE : S_SCAN_RD;
                  REQ_RELEASE, REQ_TRANSLATE: state_in = S_SCAN_RD;
                  REQ_LIST_USED, REQ_LIST_FREE: state_in = S_LCNT_RD;
                  default:                   state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN_RD: state_in = in_range ? S_SCAN_EV : S_DECIDE;
         S_SCAN_EV: state_in = (req_ff != REQ_ALLOC && is_match) ? S_DECIDE : S_SCAN_RD;
         S_DECIDE: begin
            unique case (req_ff)
               REQ_ALLOC: begin
                  if (hit_ff || (amt_ff > free_total_ff)) begin
                     state_in = S_IDLE;
                  end else if (fit_ff) begin
                     state_in = S_PLACE;
                  end else begin
                     state_in = S_CMP_RD;
                  end
               end
               REQ_RELEASE: begin
                  if (!hit_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     state_in = rel_has_next ? S_REL_RD : S_REL_MERGE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_CMP_RD:   state_in = in_range ? S_CMP_EV : S_CMP_TAIL;
         S_CMP_EV:   state_in = S_CMP_RD;
         S_CMP_TAIL: state_in = tail_ok ? S_PLACE : S_IDLE;
         S_PLACE: begin
            if (fit_size_ff != amt_ff) begin
               state_in = table_full ? S_IDLE : S_INS_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_INS_RD:    state_in = (idx_ff > fit_idx_ff) ? S_INS_WR : S_INS_FIN1;
         S_INS_WR:    state_in = S_INS_RD;
         S_INS_FIN1:  state_in = S_INS_FIN2;
         S_INS_FIN2:  state_in = S_IDLE;
         S_REL_RD:    state_in = S_REL_EV;
         S_REL_EV:    state_in = S_REL_MERGE;
         S_REL_MERGE: state_in = (rm_k_calc == 2'd0) ? S_IDLE : S_RM_RD;
         S_RM_RD:     state_in = rm_more ? S_RM_WR : S_IDLE;
         S_RM_WR:     state_in = S_RM_RD;
         S_LCNT_RD: begin
            if (in_range) begin
               state_in = S_LCNT_EV;
            end else begin
               state_in = (cnt_ff == '0) ? S_IDLE : S_LEMT_RD;
            end
         end
         S_LCNT_EV: state_in = S_LCNT_RD;
         S_LEMT_RD: state_in = S_LEMT_EV;
         S_LEMT_EV: state_in = (lst_match && k_last) ? S_IDLE : S_LEMT_RD;
         default:   state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // datapath, memory controls and result beats
   // ------------------------------------------------------------------------
   always_comb begin
      ram_size_in   = ram_size_ff;
      count_in      = count_ff;
      free_total_in = free_total_ff;
      req_in        = req_ff;
      id_in         = id_ff;
      amt_in        = amt_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_base_in   = hit_base_ff;
      hit_size_in   = hit_size_ff;
      prev_used_in  = prev_used_ff;
      prev_base_in  = prev_base_ff;
      prev_size_in  = prev_size_ff;
      fit_in        = fit_ff;
      fit_idx_in    = fit_idx_ff;
      fit_base_in   = fit_base_ff;
      fit_size_in   = fit_size_ff;
      nxf_in        = nxf_ff;
      nx_size_in    = nx_size_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      comp_in       = comp_ff;
      nw_in         = nw_ff;
      next_base_in  = next_base_ff;
      rm_k_in       = rm_k_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[IW-1:0];
      mem_wdata     = e;
      mem_raddr     = idx_ff[IW-1:0];

      unique case (state_ff)
         S_INIT: begin
            mem_we         = 1'b1;
            mem_waddr      = '0;
            mem_wdata      = '0;
            mem_wdata.size = ram_size_ff;
            count_in       = CW'(1);
            free_total_in  = ram_size_ff;
         end
         S_IDLE: begin
            if (cfg_wr) begin
               if (wv == 64'd0) begin
                  ram_size_in = SW'(1);
               end else if (wv > (64'd1 << ADDR_BITS)) begin
                  ram_size_in = SW'(64'd1 << ADDR_BITS);
               end else begin
                  ram_size_in = SW'(wv);
               end
            end else if (accept) begin
               req_in  = req_type;
               id_in   = req_process_id;
               amt_in  = req_amount;
               idx_in  = '0;
               hit_in  = 1'b0;
               fit_in  = 1'b0;
               comp_in = 1'b0;
               cnt_in  = '0;
               prev_used_in = 1'b1;
               if (req_type == REQ_ALLOC && req_amount == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = mk_rsp(ST_BADSIZE, req_process_id, '0, '0, '0, '0, 1'b0, 1'b1);
               end
            end
         end
         S_SCAN_EV: begin
            if (is_match && !hit_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = idx_ff;
               hit_base_in = e.base;
               hit_size_in = e.size;
            end
            if (!is_match) begin
               prev_used_in = e.used;
               prev_base_in = e.base;
               prev_size_in = e.size;
            end
            if (is_fit && !fit_ff) begin
               fit_in      = 1'b1;
               fit_idx_in  = idx_ff;
               fit_base_in = e.base;
               fit_size_in = e.size;
            end
            idx_in = idx_ff + CW'(1);
         end
         S_DECIDE: begin
            case (req_ff)
               REQ_ALLOC: begin
                  if (hit_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(ST_EXISTS, id_ff, '0, '0, '0, '0, 1'b0, 1'b1);
                  end else if (amt_ff > free_total_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(ST_NOMEM, id_ff, '0, '0, '0, '0, 1'b0, 1'b1);
                  end else if (!fit_ff) begin
                     idx_in       = '0;
                     nw_in        = '0;
                     next_base_in = '0;
                     comp_in      = 1'b1;
                  end
               end
               REQ_RELEASE: begin
                  if (!hit_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = mk_rsp(ST_NOTFOUND, id_ff, '0, '0, '0, '0, 1'b0, 1'b1);
                  end else begin
                     free_total_in = free_total_ff + hit_size_ff;
                     nxf_in        = 1'b0;
                  end
               end
               REQ_TRANSLATE: begin
                  rsp_valid_in = 1'b1;
                  if (!hit_ff) begin
                     rsp_in = mk_rsp(ST_NOTFOUND, id_ff, '0, '0, '0, '0, 1'b0, 1'b1);
                  end else if (amt_ff >= hit_size_ff) begin
                     rsp_in = mk_rsp(ST_BADOFF, id_ff, '0, '0, '0, '0, 1'b0, 1'b1);
                  end else begin
                     rsp_in = mk_rsp(ST_OK, id_ff, hit_base_ff,
                                     ADDR_BITS'(SW'(hit_base_ff) + hit_size_ff - SW'(1)),
                                     ADDR_BITS'(SW'(hit_base_ff) + amt_ff), '0, 1'b0, 1'b1);
                  end
               end
               default: ;
            endcase
         end
         S_CMP_EV: begin
            // slide used entries down; write index never passes read index
            if (e.used) begin
               mem_we         = 1'b1;
               mem_waddr      = nw_ff[IW-1:0];
               mem_wdata      = e;
               mem_wdata.base = next_base_ff[ADDR_BITS-1:0];
               nw_in          = nw_ff + CW'(1);
               next_base_in   = next_base_ff + e.size;
            end
            idx_in = idx_ff + CW'(1);
         end
         S_CMP_TAIL: begin
            if (tail_ok) begin
               mem_we          = 1'b1;
               mem_waddr       = nw_ff[IW-1:0];
               mem_wdata.used  = 1'b0;
               mem_wdata.owner = '0;
               mem_wdata.size  = free_total_ff;
               mem_wdata.base  = next_base_ff[ADDR_BITS-1:0];
               count_in        = nw_ff + CW'(1);
               fit_in          = 1'b1;
               fit_idx_in      = nw_ff;
               fit_base_in     = next_base_ff[ADDR_BITS-1:0];
               fit_size_in     = free_total_ff;
            end else begin
               count_in     = nw_ff;
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(ST_NOMEM, id_ff, '0, '0, '0, '0, 1'b1, 1'b1);
            end
         end
         S_PLACE: begin
            if (fit_size_ff != amt_ff) begin
               if (table_full) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = mk_rsp(ST_FULL, id_ff, '0, '0, '0, '0, comp_ff, 1'b1);
               end else begin
                  idx_in = count_ff;
               end
            end else begin
               mem_we          = 1'b1;
               mem_waddr       = fit_idx_ff[IW-1:0];
               mem_wdata.used  = 1'b1;
               mem_wdata.owner = id_ff;
               mem_wdata.size  = fit_size_ff;
               mem_wdata.base  = fit_base_ff;
               free_total_in   = free_total_ff - amt_ff;
               rsp_valid_in    = 1'b1;
               rsp_in = mk_rsp(ST_OK, id_ff, fit_base_ff,
                               ADDR_BITS'(SW'(fit_base_ff) + amt_ff - SW'(1)), '0, '0,
                               comp_ff, 1'b1);
            end
         end
         S_INS_RD: begin
            mem_raddr = IW'(idx_ff - CW'(1));
         end
         S_INS_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[IW-1:0];
            mem_wdata = e;
            idx_in    = idx_ff - CW'(1);
         end
         S_INS_FIN1: begin
            mem_we          = 1'b1;
            mem_waddr       = fit_idx_ff[IW-1:0];
            mem_wdata.used  = 1'b1;
            mem_wdata.owner = id_ff;
            mem_wdata.size  = amt_ff;
            mem_wdata.base  = fit_base_ff;
         end
         S_INS_FIN2: begin
            mem_we          = 1'b1;
            mem_waddr       = IW'(fit_idx_ff + CW'(1));
            mem_wdata.used  = 1'b0;
            mem_wdata.owner = '0;
            mem_wdata.size  = fit_size_ff - amt_ff;
            mem_wdata.base  = ADDR_BITS'(SW'(fit_base_ff) + amt_ff);
            count_in        = count_ff + CW'(1);
            free_total_in   = free_total_ff - amt_ff;
            rsp_valid_in    = 1'b1;
            rsp_in = mk_rsp(ST_OK, id_ff, fit_base_ff,
                            ADDR_BITS'(SW'(fit_base_ff) + amt_ff - SW'(1)), '0, '0,
                            comp_ff, 1'b1);
         end
         S_REL_RD: begin
            mem_raddr = IW'(hit_idx_ff + CW'(1));
         end
         S_REL_EV: begin
            nxf_in     = !e.used;
            nx_size_in = e.size;
         end
         S_REL_MERGE: begin
            mem_we          = 1'b1;
            mem_wdata.used  = 1'b0;
            mem_wdata.owner = '0;
            mem_wdata.size  = merged_size;
            if (pf) begin
               mem_waddr      = IW'(hit_idx_ff - CW'(1));
               mem_wdata.base = prev_base_ff;
               idx_in         = hit_idx_ff;
            end else begin
               mem_waddr      = hit_idx_ff[IW-1:0];
               mem_wdata.base = hit_base_ff;
               idx_in         = hit_idx_ff + CW'(1);
            end
            rm_k_in = rm_k_calc;
            if (rm_k_calc == 2'd0) begin
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(ST_OK, id_ff, hit_base_ff,
                               ADDR_BITS'(SW'(hit_base_ff) + hit_size_ff - SW'(1)), '0, '0,
                               1'b0, 1'b1);
            end
         end
         S_RM_RD: begin
            mem_raddr = rm_src[IW-1:0];
            if (!rm_more) begin
               count_in     = count_ff - CW'(rm_k_ff);
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(ST_OK, id_ff, hit_base_ff,
                               ADDR_BITS'(SW'(hit_base_ff) + hit_size_ff - SW'(1)), '0, '0,
                               1'b0, 1'b1);
            end
         end
         S_RM_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[IW-1:0];
            mem_wdata = e;
            idx_in    = idx_ff + CW'(1);
         end
         S_LCNT_RD: begin
            if (!in_range) begin
               idx_in = '0;
               k_in   = '0;
               if (cnt_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = mk_rsp(ST_EMPTY, '0, '0, '0, '0, '0, 1'b0, 1'b1);
               end else if (32'(cnt_ff) > LIST_MAX) begin
                  cnt_in = CW'(LIST_MAX);
               end
            end
         end
         S_LCNT_EV: begin
            if (lst_match) begin
               cnt_in = cnt_ff + CW'(1);
            end
            idx_in = idx_ff + CW'(1);
         end
         S_LEMT_EV: begin
            if (lst_match) begin
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(ST_OK, want_used ? e.owner : '0, e.base,
                               ADDR_BITS'(SW'(e.base) + e.size - SW'(1)), '0,
                               want_used ? '0 : k_ff[FIDX_W-1:0], 1'b0, k_last);
               k_in = k_ff + 5'd1;
            end
            idx_in = idx_ff + CW'(1);
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // register update
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         ram_size_ff   <= SW'(64'd1 << ADDR_BITS);
         count_ff      <= CW'(1);
         free_total_ff <= SW'(64'd1 << ADDR_BITS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ram_size_ff   <= ram_size_in;
         count_ff      <= count_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      id_ff        <= id_in;
      amt_ff       <= amt_in;
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_base_ff  <= hit_base_in;
      hit_size_ff  <= hit_size_in;
      prev_used_ff <= prev_used_in;
      prev_base_ff <= prev_base_in;
      prev_size_ff <= prev_size_in;
      fit_ff       <= fit_in;
      fit_idx_ff   <= fit_idx_in;
      fit_base_ff  <= fit_base_in;
      fit_size_ff  <= fit_size_in;
      nxf_ff       <= nxf_in;
      nx_size_ff   <= nx_size_in;
      cnt_ff       <= cnt_in;
      k_ff         <= k_in;
      comp_ff      <= comp_in;
      nw_ff        <= nw_in;
      next_base_ff <= next_base_in;
      rm_k_ff      <= rm_k_in;
      rsp_ff       <= rsp_in;
   end

   // ------------------------------------------------------------------------
   // outputs
   // ------------------------------------------------------------------------
   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_owner_id   = rsp_ff.owner;
   assign rsp_seg_base   = rsp_ff.base;
   assign rsp_seg_bound  = rsp_ff.bound;
   assign rsp_phys_addr  = rsp_ff.phys;
   assign rsp_free_index = rsp_ff.fidx;
   assign rsp_compacted  = rsp_ff.comp;
   assign rsp_last       = rsp_ff.last;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(ram_size_ff);

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit segment allocator. A local model of
// the segment table predicts every result beat; directed tests cover the
// error codes, splits, merges, compaction, a full table and long listings,
// then random allocate/release/translate/list traffic runs at several RAM
// sizes written over the CSR port.
// ----------------------------------------------------------------------------
module testbench
   import ffsa_pkg::*;
();

   localparam int NSEG  = 16;
   localparam int AW    = 20;
   localparam int IW    = 8;
   localparam int RAM_MAX = 1 << AW;
   localparam logic [2:0] CSR_RAM_SIZE = 3'd0;
   localparam int CYCLE_LIMIT = 600000;

   // request codes with no function
   localparam logic [REQ_W-1:0] REQ_RSVD_5 = 3'd5;
   localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
   localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IW-1:0]       owner;
      logic [AW-1:0]       base;
      logic [AW-1:0]       bound;
      logic [AW-1:0]       phys;
      logic [FIDX_W-1:0]   fidx;
      logic                comp;
      logic                last;
   } beat_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [REQ_W-1:0] req_type = '0;
   logic [IW-1:0] req_process_id = '0;
   logic [AW:0] req_amount = '0;
   logic rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [IW-1:0] rsp_owner_id;
   logic [AW-1:0] rsp_seg_base, rsp_seg_bound, rsp_phys_addr;
   logic [FIDX_W-1:0] rsp_free_index;
   logic rsp_compacted, rsp_last;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   first_fit_segment_allocator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_process_id(req_process_id),
      .req_amount(req_amount), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_owner_id(rsp_owner_id), .rsp_seg_base(rsp_seg_base),
      .rsp_seg_bound(rsp_seg_bound), .rsp_phys_addr(rsp_phys_addr),
      .rsp_free_index(rsp_free_index), .rsp_compacted(rsp_compacted),
      .rsp_last(rsp_last), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Segment table model
   // ---------------------------------------------------------------------
   longint seg_base[NSEG], seg_size[NSEG];
   logic [IW-1:0] seg_owner[NSEG];
   bit seg_used[NSEG];
   int seg_count;
   longint mem_free, mem_size;

   beat_type expected_beats[$];
   int fail_count = 0;
   int cycles = 0;
   bit quiet = 0;      // when set, the sender adds no random idle gaps

   function automatic void table_rebuild();
      for (int i = 0; i < NSEG; i++) begin
         seg_base[i] = 0; seg_size[i] = 0; seg_owner[i] = 0; seg_used[i] = 0;
      end
      seg_size[0] = mem_size;
      seg_count = 1;
      mem_free = mem_size;
   endfunction

   function automatic void push_beat(logic [STATUS_W-1:0] st, longint own,
         longint b, longint bd, longint ph, int fi, bit cp, bit lst);
      beat_type x;
      x.status = st; x.owner = own[IW-1:0]; x.base = b[AW-1:0];
      x.bound = bd[AW-1:0]; x.phys = ph[AW-1:0]; x.fidx = fi[FIDX_W-1:0];
      x.comp = cp; x.last = lst;
      expected_beats.push_back(x);
   endfunction

   function automatic int owner_slot(logic [IW-1:0] id);
      for (int i = 0; i < seg_count; i++)
         if (seg_used[i] && seg_owner[i] == id) return i;
      return -1;
   endfunction

   function automatic int fit_slot(longint amt);
      for (int i = 0; i < seg_count; i++)
         if (!seg_used[i] && seg_size[i] >= amt) return i;
      return -1;
   endfunction

   function automatic void drop_slot(int i);
      for (int j = i; j + 1 < seg_count; j++) begin
         seg_base[j] = seg_base[j+1]; seg_size[j] = seg_size[j+1];
         seg_owner[j] = seg_owner[j+1]; seg_used[j] = seg_used[j+1];
      end
      seg_count--;
      seg_base[seg_count] = 0; seg_size[seg_count] = 0;
      seg_owner[seg_count] = 0; seg_used[seg_count] = 0;
   endfunction

   // slide used segments to the bottom, one free block on top if free memory and a slot remain
   function automatic void squeeze_table();
      int n;
      longint nxt;
      n = 0; nxt = 0;
      for (int i = 0; i < seg_count; i++)
         if (seg_used[i]) begin
            seg_base[n] = nxt; seg_size[n] = seg_size[i];
            seg_owner[n] = seg_owner[i]; seg_used[n] = 1;
            nxt += seg_size[i]; n++;
         end
      if (mem_free > 0 && n < NSEG) begin
         seg_base[n] = nxt; seg_size[n] = mem_free;
         seg_owner[n] = 0; seg_used[n] = 0; n++;
      end
      for (int i = n; i < NSEG; i++) begin
         seg_base[i] = 0; seg_size[i] = 0; seg_owner[i] = 0; seg_used[i] = 0;
      end
      seg_count = n;
   endfunction

   function automatic void predict_request(logic [REQ_W-1:0] rt,
         logic [IW-1:0] id, longint amt);
      int f, n, k;
      bit cp, want;
      longint b, bd;
      case (rt)
         REQ_ALLOC: begin
            cp = 0;
            if (amt == 0) begin push_beat(ST_BADSIZE, id, 0, 0, 0, 0, 0, 1); return; end
            if (owner_slot(id) >= 0) begin push_beat(ST_EXISTS, id, 0, 0, 0, 0, 0, 1); return; end
            if (amt > mem_free) begin push_beat(ST_NOMEM, id, 0, 0, 0, 0, 0, 1); return; end
            f = fit_slot(amt);
            if (f < 0) begin
               squeeze_table(); cp = 1; f = fit_slot(amt);
               if (f < 0) begin push_beat(ST_NOMEM, id, 0, 0, 0, 0, cp, 1); return; end
            end
            if (seg_size[f] != amt) begin
               if (seg_count >= NSEG) begin
                  push_beat(ST_FULL, id, 0, 0, 0, 0, cp, 1); return;
               end
               for (int j = seg_count; j > f; j--) begin
                  seg_base[j] = seg_base[j-1]; seg_size[j] = seg_size[j-1];
                  seg_owner[j] = seg_owner[j-1]; seg_used[j] = seg_used[j-1];
               end
               seg_count++;
               seg_size[f] = amt;
               seg_base[f+1] += amt;
               seg_size[f+1] -= amt;
            end
            seg_used[f] = 1; seg_owner[f] = id; mem_free -= amt;
            push_beat(ST_OK, id, seg_base[f], seg_base[f] + amt - 1, 0, 0, cp, 1);
         end
         REQ_RELEASE: begin
            f = owner_slot(id);
            if (f < 0) begin push_beat(ST_NOTFOUND, id, 0, 0, 0, 0, 0, 1); return; end
            b = seg_base[f]; bd = b + seg_size[f] - 1;
            seg_used[f] = 0; seg_owner[f] = 0; mem_free += seg_size[f];
            if (f + 1 < seg_count && !seg_used[f+1]) begin
               seg_size[f] += seg_size[f+1]; drop_slot(f + 1);
            end
            if (f > 0 && !seg_used[f-1]) begin
               seg_size[f-1] += seg_size[f]; drop_slot(f);
            end
            push_beat(ST_OK, id, b, bd, 0, 0, 0, 1);
         end
         REQ_TRANSLATE: begin
            f = owner_slot(id);
            if (f < 0) push_beat(ST_NOTFOUND, id, 0, 0, 0, 0, 0, 1);
            else if (amt >= seg_size[f]) push_beat(ST_BADOFF, id, 0, 0, 0, 0, 0, 1);
            else push_beat(ST_OK, id, seg_base[f], seg_base[f] + seg_size[f] - 1,
                           seg_base[f] + amt, 0, 0, 1);
         end
         REQ_LIST_USED, REQ_LIST_FREE: begin
            want = (rt == REQ_LIST_USED);
            n = 0; k = 0;
            for (int i = 0; i < seg_count; i++) if (seg_used[i] == want) n++;
            if (n > LIST_MAX) n = LIST_MAX;
            if (n == 0) begin push_beat(ST_EMPTY, 0, 0, 0, 0, 0, 0, 1); return; end
            for (int i = 0; i < seg_count && k < n; i++)
               if (seg_used[i] == want) begin
                  push_beat(ST_OK, want ? seg_owner[i] : 0, seg_base[i],
                            seg_base[i] + seg_size[i] - 1, 0, want ? 0 : k, 0,
                            k + 1 == n);
                  k++;
               end
         end
         default: ;  // unknown code: no beat, no change
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: every rsp_valid beat is popped against the model
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      beat_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         got = '{rsp_status, rsp_owner_id, rsp_seg_base, rsp_seg_bound,
                 rsp_phys_addr, rsp_free_index, rsp_compacted, rsp_last};
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, got);
            fail_count++;
         end else begin
            want = expected_beats.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, got);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock)
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   task automatic send_request(logic [REQ_W-1:0] rt, int id, longint amt);
      while (!quiet && $urandom_range(99) < 24) @(posedge clock);
      start <= 1; req_type <= rt; req_process_id <= id[IW-1:0];
      req_amount <= amt[AW:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_request(rt, id[IW-1:0], amt);
      start <= 0;
      // busy covers the whole request, so wait for it to drop before next
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);  // settle time; unknown codes leave the block idle
   endtask

   task automatic write_ram_size(longint val);
      longint v;
      drain();
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= CSR_RAM_SIZE; csr_pwdata <= val[31:0];
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
      v = val;
      if (v < 1) v = 1;
      if (v > RAM_MAX) v = RAM_MAX;
      mem_size = v;
      table_rebuild();
      while (busy) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_errors_and_edges();
      send_request(REQ_LIST_USED, 0, 0);           // empty used list
      send_request(REQ_ALLOC, 8'hFF, 0);           // zero size
      send_request(REQ_ALLOC, 0, RAM_MAX + 1);     // too large, top amount bit
      send_request(REQ_ALLOC, 0, 100);             // id zero is a real owner
      send_request(REQ_ALLOC, 0, 5);               // duplicate id
      send_request(REQ_TRANSLATE, 0, 99);          // last valid offset
      send_request(REQ_TRANSLATE, 0, 100);         // offset past the end
      send_request(REQ_TRANSLATE, 8'hAA, 0);       // unknown id
      send_request(REQ_RELEASE, 8'h55, 0);         // unknown id
      send_request(REQ_RSVD_5, 1, 1);              // unknown codes
      send_request(REQ_RSVD_6, 1, 1);
      send_request(REQ_RSVD_7, 8'hFF, 21'h1FFFFF);
      send_request(REQ_ALLOC, 8'hFF, RAM_MAX - 100); // takes the rest exactly
      send_request(REQ_LIST_FREE, 0, 0);           // empty free list
      send_request(REQ_TRANSLATE, 8'hFF, RAM_MAX - 101);
      send_request(REQ_RELEASE, 0, 0);
      send_request(REQ_RELEASE, 8'hFF, 0);         // merge to one block
      send_request(REQ_LIST_FREE, 0, 0);
   endtask

   // small RAM: three-way merge, compaction, full table, long lists
   task automatic test_fragmentation();
      write_ram_size(64);
      for (int i = 1; i <= 6; i++) send_request(REQ_ALLOC, i, 4);
      send_request(REQ_RELEASE, 2, 0);
      send_request(REQ_RELEASE, 4, 0);
      send_request(REQ_RELEASE, 3, 0);             // merges both neighbors
      send_request(REQ_ALLOC, 7, 30);
      send_request(REQ_RELEASE, 1, 0);
      send_request(REQ_RELEASE, 5, 0);
      send_request(REQ_ALLOC, 8, 30);              // compaction first
      send_request(REQ_LIST_USED, 0, 0);
      write_ram_size(32);
      for (int i = 0; i < 16; i++) send_request(REQ_ALLOC, 20 + i, 1);
      send_request(REQ_RELEASE, 21, 0);
      send_request(REQ_RELEASE, 23, 0);
      send_request(REQ_ALLOC, 50, 2);              // top block fits, table full
      send_request(REQ_LIST_USED, 0, 0);
      send_request(REQ_LIST_FREE, 0, 0);
      write_ram_size(16);
      for (int i = 0; i < 16; i += 2) send_request(REQ_ALLOC, i, 1);
      for (int i = 0; i < 16; i += 2) send_request(REQ_ALLOC, i + 1, 1);
      for (int i = 0; i < 16; i += 2) send_request(REQ_RELEASE, i, 0);
      send_request(REQ_LIST_FREE, 0, 0);           // one merged free block of eight
   endtask

   task automatic test_random(longint size, int count);
      longint amt;
      logic [REQ_W-1:0] rt;
      write_ram_size(size);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(99)) inside
            [0:39]: rt = REQ_ALLOC;
            [40:64]: rt = REQ_RELEASE;
            [65:84]: rt = REQ_TRANSLATE;
            [85:91]: rt = REQ_LIST_USED;
            [92:97]: rt = REQ_LIST_FREE;
            default: rt = REQ_RSVD_5 + REQ_W'($urandom_range(2));
         endcase
         if (rt == REQ_ALLOC)
            amt = ($urandom_range(9) == 0) ? $urandom_range(21'h1FFFFF)
                                           : $urandom_range(size / 4 + 1);
         else if (rt == REQ_TRANSLATE)
            amt = ($urandom_range(9) == 0) ? $urandom_range(21'h1FFFFF)
                                           : $urandom_range(size / 3 + 1);
         else
            amt = $urandom_range(21'h1FFFFF);
         send_request(rt, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                     : $urandom_range(11), amt);
      end
   endtask

   task automatic test_pause_and_burst();
      drain();                   // sender holds off until all beats are in
      quiet = 1;
      test_random(1000, 12);
      quiet = 0;
   endtask

   initial begin
      mem_size = RAM_MAX;
      table_rebuild();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);
      test_errors_and_edges();
      test_fragmentation();
      test_random(1, 6);
      test_random(200, 16);
      test_pause_and_burst();
      test_random(RAM_MAX, 16);
      write_ram_size(0);          // clamps to one unit
      send_request(REQ_ALLOC, 3, 1);
      write_ram_size(32'hFFFFFFFF); // clamps to the top
      send_request(REQ_LIST_FREE, 0, 0);
      drain();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
